// ===== hdl/swm_pkg.sv =====
// Shared definitions for the sliding window median filter.
// Holds widths, reset values and the link type passed between sorting cells.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CFG_W          = 7;
  localparam logic [CFG_W-1:0] WSIZE_RESET = 7'd3;

  typedef struct packed {
    logic v;
    logic keep;
    logic gt;
    logic kb;
  } cell_link_t;

endpackage

// ===== hdl/swm_prefix.sv =====
// Exclusive prefix OR across the cell row, used to find the first entry to remove.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module swm_prefix #(
  parameter int unsigned N = 64
) (
  input  logic [N-1:0] cand,
  output logic [N-1:0] preceding,
  output logic         any_set
);

  logic [N-1:0] acc;

  always_comb begin
    acc = cand;
    for (int s = 1; s < N; s = s * 2) begin
      acc = acc | (acc << s);
    end
  end

  assign preceding = acc << 1;
  assign any_set   = acc[N-1];

endmodule

// ===== hdl/swm_cell.sv =====
// One sorting cell: a value, its age and a valid bit, reloaded from itself, a neighbour or the input sample.
// Depends on swm_pkg for the data width and the link type.
`timescale 1ns / 1ps

module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int unsigned AW = $clog2(MAX_WINDOW),
  localparam int unsigned WW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     purge,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] sample,
  input  logic [WW-1:0]            w,
  input  logic                     kb,
  input  logic                     anykill,
  input  cell_link_t               llink,
  input  logic signed [DATA_W-1:0] lvalue,
  input  logic [AW-1:0]            lage,
  input  cell_link_t               rlink,
  input  logic signed [DATA_W-1:0] rvalue,
  input  logic [AW-1:0]            rage,
  output cell_link_t               link,
  output logic                     cand,
  output logic                     vld,
  output logic signed [DATA_W-1:0] value,
  output logic [AW-1:0]            age
);

  logic                     v;
  logic [WW-1:0]            age_x;
  logic                     kill;
  logic                     keep;
  logic                     gt;
  logic                     from_r;
  logic                     from_s;
  logic                     from_l;
  logic                     in_range;
  logic                     ins;
  logic [AW-1:0]            inc;
  logic                     vld_next;
  logic signed [DATA_W-1:0] value_next;
  logic [AW-1:0]            age_next;

  always_comb begin
    v     = vld & ~(step & start);
    age_x = WW'(age);
    if (step) begin
      cand = v && ((age_x + WW'(1)) >= w);
    end else begin
      cand = purge && v && (age_x >= w);
    end
    kill     = cand & ~kb;
    keep     = v & ~kill;
    gt       = step & v & (value > sample);
    link     = '{v: v, keep: keep, gt: gt, kb: kb};
    from_r   = rlink.keep & rlink.kb & ~rlink.gt;
    from_s   = keep & (kb == gt);
    from_l   = llink.keep & ~llink.kb & llink.gt;
    in_range = anykill ? v : (v | llink.v);
    ins      = step & in_range & ~(from_r | from_s | from_l);
    inc      = AW'(step);
    vld_next   = from_r | from_s | from_l | ins;
    value_next = value;
    age_next   = age;
    priority if (from_r) begin
      value_next = rvalue;
      age_next   = rage + inc;
    end else if (from_s) begin
      age_next   = age + inc;
    end else if (from_l) begin
      value_next = lvalue;
      age_next   = lage + inc;
    end else if (ins) begin
      value_next = sample;
      age_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (step | purge) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step | purge) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// ===== hdl/sliding_window_median.sv =====
// Sliding window median filter top level: a row of sorting cells and the output register.
// Depends on swm_pkg, swm_cell and swm_prefix.
`timescale 1ns / 1ps

// The block takes one sample beat in every clock cycle while median beats are taken, and keeps
// the window sorted in a row of MAX_WINDOW cells, each shifting by at most one place per beat;
// once the window is full, each sample is marked pending and its median beat is then loaded into
// an output register that lets the next sample be taken while it waits. A write on cfg_we holds
// the input in the write cycle and while the purge that follows it runs; a write that shrinks
// the window first drops the surplus entries one per cycle. The clock period is set by the age
// compare in each cell followed by the prefix OR across the whole row.

module sliding_window_median
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     start_req,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] median
);

  localparam int unsigned N    = MAX_WINDOW;
  localparam int unsigned AW   = $clog2(N);
  localparam int unsigned WW   = $clog2(N + 1);
  localparam int unsigned WRST = (int'(WSIZE_RESET) > N) ? N : int'(WSIZE_RESET);

  cell_link_t               link [N];
  logic signed [DATA_W-1:0] cval [N];
  logic [AW-1:0]            cage [N];
  logic [N-1:0]             cand;
  logic [N-1:0]             kb;
  logic [N-1:0]             vld;
  logic                     any_set;

  logic [WW-1:0]            weff;
  logic [WW-1:0]            weff_next;
  logic [31:0]              wd;
  logic                     purging;
  logic                     pend;
  logic                     step;
  logic                     full;
  logic                     go;
  logic [AW-1:0]            wm1;
  logic [AW-1:0]            rank;
  logic signed [DATA_W-1:0] med_sel;

  always_comb begin
    wd = 32'(cfg_wdata);
    if (wd == 32'd0) begin
      weff_next = WW'(1);
    end else if (wd > 32'(N)) begin
      weff_next = WW'(N);
    end else begin
      weff_next = WW'(wd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weff <= WW'(WRST);
    end else if (cfg_we) begin
      weff <= weff_next;
    end
  end

  assign wm1  = AW'(weff - WW'(1));
  assign rank = AW'((weff - WW'(1)) >> 1);
  assign full = vld[wm1];

  assign in_ready = ~purging & ~cfg_we & (~pend | ~full | ~out_valid | out_ready);
  assign step     = in_valid & in_ready;
  assign go       = pend & full & (~out_valid | out_ready);

  swm_prefix #(.N(N)) u_prefix (
    .cand      (cand),
    .preceding (kb),
    .any_set   (any_set)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    cell_link_t               llink;
    cell_link_t               rlink;
    logic signed [DATA_W-1:0] lvalue;
    logic signed [DATA_W-1:0] rvalue;
    logic [AW-1:0]            lage;
    logic [AW-1:0]            rage;

    if (i == 0) begin : g_first
      assign llink  = '{v: 1'b1, keep: 1'b0, gt: 1'b0, kb: 1'b0};
      assign lvalue = '0;
      assign lage   = '0;
    end else begin : g_inner_l
      assign llink  = link[i-1];
      assign lvalue = cval[i-1];
      assign lage   = cage[i-1];
    end

    if (i == N - 1) begin : g_last
      assign rlink  = '{v: 1'b0, keep: 1'b0, gt: 1'b0, kb: 1'b0};
      assign rvalue = '0;
      assign rage   = '0;
    end else begin : g_inner_r
      assign rlink  = link[i+1];
      assign rvalue = cval[i+1];
      assign rage   = cage[i+1];
    end

    swm_cell #(.MAX_WINDOW(N)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .step    (step),
      .purge   (purging),
      .start   (start_req),
      .sample  (sample),
      .w       (weff),
      .kb      (kb[i]),
      .anykill (any_set),
      .llink   (llink),
      .lvalue  (lvalue),
      .lage    (lage),
      .rlink   (rlink),
      .rvalue  (rvalue),
      .rage    (rage),
      .link    (link[i]),
      .cand    (cand[i]),
      .vld     (vld[i]),
      .value   (cval[i]),
      .age     (cage[i])
    );
  end

  always_comb begin
    med_sel = '0;
    for (int i = 0; i < N; i++) begin
      if (AW'(i) == rank) begin
        med_sel = cval[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      purging   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        purging <= 1'b1;
      end else if (purging && !any_set) begin
        purging <= 1'b0;
      end
      if (step) begin
        pend <= 1'b1;
      end else if (go || !full) begin
        pend <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      median <= med_sel;
    end
  end

  // The valid cells always form an unbroken run starting at the first cell.
  a_contiguous : assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, vld} + {{N{1'b0}}, 1'b1}))
    else $error("valid cells do not form a contiguous run");

  // A start beat leaves exactly one entry in the row.
  a_start : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && start_req) |=> (vld[0] && !vld[1]))
    else $error("start beat did not empty the window");

  // A pending full-window result reaches an empty output register in the next cycle.
  a_result : assert property (@(posedge clk) disable iff (rst)
    (pend && full && !out_valid) |=> out_valid)
    else $error("pending median was not presented");

endmodule
